// ===== sv/lruc_pkg.sv =====
// ============================================================================
// lruc_pkg: shared types and constants of the LRU age tag cache
// Port widths, default sizing, request codes, sequencer states and the
// flag group that the entry unit hands to the sequencer.
// ============================================================================
package lruc_pkg;

    // Fixed port widths of the request and response beats
    localparam int KEY_W  = 64;
    localparam int SLOT_W = 4;
    localparam int SIZE_W = 20;

    // Default sizing of the table
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_KEY_BITS  = 64;
    localparam int DEF_AGE_BITS  = 16;
    localparam int DEF_SIZE_BITS = 20;

    // Request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AGE,
        ST_WAIT
    } seq_state_t;

    // Flags from the shared entry unit
    typedef struct packed {
        logic match;
        logic older;
    } unit_flags_t;

endpackage

// ===== sv/lruc_ram.sv =====
// ============================================================================
// lruc_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ============================================================================
module lruc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lruc_entry_unit.sv =====
// ============================================================================
// lruc_entry_unit: shared per-entry compare and age unit
// Compares one stored key with the request key, forms the saturated aged
// value of the entry and compares it with the oldest age seen so far.
// ============================================================================
module lruc_entry_unit #(
    parameter int KEY_BITS = lruc_pkg::DEF_KEY_BITS,
    parameter int AGE_BITS = lruc_pkg::DEF_AGE_BITS
) (
    input  logic [KEY_BITS-1:0]     ent_key,
    input  logic [AGE_BITS-1:0]     ent_age,
    input  logic [KEY_BITS-1:0]     cmp_key,
    input  logic [AGE_BITS-1:0]     oldest,
    output logic [AGE_BITS-1:0]     aged,
    output lruc_pkg::unit_flags_t   flags
);

    import lruc_pkg::*;

    // Saturating increment of the entry age
    always_comb
    begin
        if (ent_age == {AGE_BITS{1'b1}})
        begin
            aged = ent_age;
        end
        else
        begin
            aged = ent_age + AGE_BITS'(1);
        end
    end

    // Key match and age compare
    always_comb
    begin
        flags.match = (ent_key == cmp_key);
        flags.older = (aged > oldest);
    end

endmodule

// ===== sv/lruc_seq.sv =====
// ============================================================================
// lruc_seq: request sequencer of the LRU age tag cache
// Walks the entry RAM one slot per cycle: a key scan for lookups and an
// age pass for misses and inserts. Holds valid bits, victim tracking and
// the output register of the response beat.
// ============================================================================
module lruc_seq #(
    parameter int ENTRIES   = lruc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS  = lruc_pkg::DEF_KEY_BITS,
    parameter int AGE_BITS  = lruc_pkg::DEF_AGE_BITS,
    parameter int SIZE_BITS = lruc_pkg::DEF_SIZE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [lruc_pkg::KEY_W-1:0]    key,
    input  logic [lruc_pkg::SLOT_W-1:0]   slot,
    input  logic [lruc_pkg::SIZE_W-1:0]   obj_size,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [lruc_pkg::SLOT_W-1:0]   slot_out,
    output logic [lruc_pkg::SIZE_W-1:0]   stored_size,
    output logic [$clog2(ENTRIES)-1:0]    rd_addr,
    input  logic [KEY_BITS-1:0]           ent_key,
    input  logic [SIZE_BITS-1:0]          ent_size,
    input  logic [AGE_BITS-1:0]           aged,
    input  lruc_pkg::unit_flags_t         flags,
    output logic [KEY_BITS-1:0]           cmp_key,
    output logic [AGE_BITS-1:0]           oldest,
    output logic                          wr_en,
    output logic [$clog2(ENTRIES)-1:0]    wr_addr,
    output logic [KEY_BITS-1:0]           wr_key,
    output logic [SIZE_BITS-1:0]          wr_size,
    output logic [AGE_BITS-1:0]           wr_age
);

    import lruc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    seq_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [KEY_BITS-1:0]  req_key_reg, req_key_next;
    logic [SIZE_BITS-1:0] req_size_reg, req_size_next;
    logic [IDX_W-1:0]     req_idx_reg, req_idx_next;
    logic                 req_ins_reg, req_ins_next;
    logic                 found_inv_reg, found_inv_next;
    logic [IDX_W-1:0]     victim_reg, victim_next;
    logic [AGE_BITS-1:0]  oldest_reg, oldest_next;
    logic                 res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [SIZE_W-1:0]    res_size_reg, res_size_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [SIZE_W-1:0]    out_size_reg, out_size_next;

    logic                 accept;
    logic                 slot_in_range;
    logic                 data_ok;
    logic                 last;
    logic [IDX_W-1:0]     didx;
    logic                 scan_hit;
    logic                 out_free;

    // Walk status: read data belongs to the address of the step before, through the registered RAM read
    assign accept        = in_valid && in_ready;
    assign slot_in_range = (32'(slot) < ENTRIES);
    assign data_ok       = (cnt_reg != '0);
    assign last          = (cnt_reg == CNT_W'(ENTRIES));
    assign didx          = IDX_W'(cnt_reg - CNT_W'(1));
    assign scan_hit      = data_ok && valid_reg[didx] && flags.match;
    assign out_free      = !out_valid_reg || out_ready;
    assign rd_addr       = IDX_W'(cnt_reg);
    assign cmp_key       = req_key_reg;
    assign oldest        = oldest_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_LOOKUP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (slot_in_range)
                    begin
                        state_next = ST_AGE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = ST_WAIT;
                end
                else if (last)
                begin
                    state_next = ST_AGE;
                end
            end
            ST_AGE:
            begin
                if (last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs: handshake and RAM write port
    always_comb
    begin
        in_ready = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = didx;
        wr_key   = ent_key;
        wr_size  = ent_size;
        wr_age   = aged;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                // Refresh the hit entry
                if (scan_hit)
                begin
                    wr_en  = 1'b1;
                    wr_age = '0;
                end
            end
            ST_AGE:
            begin
                // Age every entry; an insert lands in its slot already aged once
                if (data_ok)
                begin
                    wr_en = 1'b1;
                    if (req_ins_reg && (didx == req_idx_reg))
                    begin
                        wr_key  = req_key_reg;
                        wr_size = req_size_reg;
                        wr_age  = AGE_BITS'(1);
                    end
                end
            end
            ST_WAIT:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath and bookkeeping
    always_comb
    begin
        cnt_next       = cnt_reg;
        valid_next     = valid_reg;
        req_key_next   = req_key_reg;
        req_size_next  = req_size_reg;
        req_idx_next   = req_idx_reg;
        req_ins_next   = req_ins_reg;
        found_inv_next = found_inv_reg;
        victim_next    = victim_reg;
        oldest_next    = oldest_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_size_next  = res_size_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_slot_next  = out_slot_reg;
        out_size_next  = out_size_reg;

        // Drop the response beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Capture the request beat
                if (accept)
                begin
                    cnt_next       = '0;
                    req_key_next   = KEY_BITS'(key);
                    req_size_next  = SIZE_BITS'(obj_size);
                    req_idx_next   = IDX_W'(slot);
                    req_ins_next   = (req_type == REQ_INSERT);
                    found_inv_next = 1'b0;
                    res_hit_next   = 1'b0;
                    res_slot_next  = slot;
                    res_size_next  = '0;
                    if ((req_type == REQ_INSERT) && slot_in_range)
                    begin
                        valid_next[IDX_W'(slot)] = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (scan_hit)
                begin
                    res_hit_next  = 1'b1;
                    res_slot_next = SLOT_W'(didx);
                    res_size_next = SIZE_W'(ent_size);
                end
                else if (last)
                begin
                    cnt_next = '0;
                end
            end
            ST_AGE:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                // Track the victim: first free slot, else oldest after aging
                if (data_ok && !req_ins_reg && !found_inv_reg)
                begin
                    if (!valid_reg[didx])
                    begin
                        found_inv_next = 1'b1;
                        victim_next    = didx;
                    end
                    else if ((didx == '0) || flags.older)
                    begin
                        victim_next = didx;
                        oldest_next = aged;
                    end
                end
                if (!req_ins_reg)
                begin
                    res_slot_next = SLOT_W'(victim_next);
                end
            end
            ST_WAIT:
            begin
                // Advance the result into the output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_slot_next  = res_slot_reg;
                    out_size_next  = res_size_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_key_reg   <= req_key_next;
        req_size_reg  <= req_size_next;
        req_idx_reg   <= req_idx_next;
        req_ins_reg   <= req_ins_next;
        found_inv_reg <= found_inv_next;
        victim_reg    <= victim_next;
        oldest_reg    <= oldest_next;
        res_hit_reg   <= res_hit_next;
        res_slot_reg  <= res_slot_next;
        res_size_reg  <= res_size_next;
        out_hit_reg   <= out_hit_next;
        out_slot_reg  <= out_slot_next;
        out_size_reg  <= out_size_next;
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign slot_out    = out_slot_reg;
    assign stored_size = out_size_reg;

endmodule

// ===== sv/lru_age_tag_cache_core.sv =====
// ============================================================================
// lru_age_tag_cache_core: fully associative tag cache with LRU ages
// Top level: entry RAM, shared entry unit and request sequencer.
// ============================================================================
// A lookup compares its key with every valid entry; a hit returns the lowest
// matching slot and its stored size and clears that entry's age, a miss ages
// all entries and returns the lowest free slot or else the oldest entry. An
// insert writes key and size into the given slot and then ages all entries;
// an insert to a slot beyond the table changes nothing and echoes the slot.
// The table sits in one RAM with a single read port that the sequencer walks
// one entry per cycle. A lookup scans up to its first hit; a miss scans the
// whole table and then makes an age pass over it; an insert makes the age
// pass alone, and an insert to a slot beyond the table goes straight to the
// output register. One request is in work at a time; the finished response
// waits in its output register while the next request is taken.
// Valid bits are cleared by reset; no clearing pass is needed.
module lru_age_tag_cache_core #(
    parameter int ENTRIES   = lruc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS  = lruc_pkg::DEF_KEY_BITS,
    parameter int AGE_BITS  = lruc_pkg::DEF_AGE_BITS,
    parameter int SIZE_BITS = lruc_pkg::DEF_SIZE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [lruc_pkg::KEY_W-1:0]  key,
    input  logic [lruc_pkg::SLOT_W-1:0] slot,
    input  logic [lruc_pkg::SIZE_W-1:0] obj_size,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic [lruc_pkg::SLOT_W-1:0] slot_out,
    output logic [lruc_pkg::SIZE_W-1:0] stored_size
);

    import lruc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int ENT_W = KEY_BITS + SIZE_BITS + AGE_BITS;

    logic [IDX_W-1:0]     rd_addr;
    logic [ENT_W-1:0]     rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_BITS-1:0]  wr_key;
    logic [SIZE_BITS-1:0] wr_size;
    logic [AGE_BITS-1:0]  wr_age;
    logic [KEY_BITS-1:0]  ent_key;
    logic [SIZE_BITS-1:0] ent_size;
    logic [AGE_BITS-1:0]  ent_age;
    logic [KEY_BITS-1:0]  cmp_key;
    logic [AGE_BITS-1:0]  oldest;
    logic [AGE_BITS-1:0]  aged;
    unit_flags_t          flags;

    // Split the stored entry word
    assign ent_key  = rd_data[ENT_W-1 -: KEY_BITS];
    assign ent_size = rd_data[AGE_BITS +: SIZE_BITS];
    assign ent_age  = rd_data[AGE_BITS-1:0];

    // Entry table: key, size and age per slot
    lruc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({wr_key, wr_size, wr_age}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare and age unit
    lruc_entry_unit #(
        .KEY_BITS (KEY_BITS),
        .AGE_BITS (AGE_BITS)
    ) u_unit (
        .ent_key (ent_key),
        .ent_age (ent_age),
        .cmp_key (cmp_key),
        .oldest  (oldest),
        .aged    (aged),
        .flags   (flags)
    );

    // Request sequencer
    lruc_seq #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .AGE_BITS  (AGE_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .slot        (slot),
        .obj_size    (obj_size),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .slot_out    (slot_out),
        .stored_size (stored_size),
        .rd_addr     (rd_addr),
        .ent_key     (ent_key),
        .ent_size    (ent_size),
        .aged        (aged),
        .flags       (flags),
        .cmp_key     (cmp_key),
        .oldest      (oldest),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_key      (wr_key),
        .wr_size     (wr_size),
        .wr_age      (wr_age)
    );

endmodule

// ===== sv/lruc_checker.sv =====
// ============================================================================
// lruc_checker: port-level checks of the LRU age tag cache
// Watches the request and response channels of the top level over time.
// ============================================================================
module lruc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        hit,
    input logic [lruc_pkg::SLOT_W-1:0] slot_out,
    input logic [lruc_pkg::SIZE_W-1:0] stored_size
);

    import lruc_pkg::*;

    // A miss or insert response carries no size
    a_size_zero_on_miss: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (stored_size == '0)
    ) else $error("nonzero size on a miss or insert response");

    // One request in work: no accept right after an accept
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("request accepted while the previous one is in work");

    // A stalled response beat holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(hit) && $stable(slot_out) && $stable(stored_size))
    ) else $error("response beat changed while stalled");

endmodule

bind lru_age_tag_cache_core lruc_checker u_lruc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .slot_out    (slot_out),
    .stored_size (stored_size)
);
